FILE: rtl/core/qrm_pkg.sv
package qrm_pkg;

	localparam int PIXEL_COORD_BITS = 12;
	localparam int CORNER_FRAC_BITS = 4;

	localparam int CORNER_W    = 16;
	localparam int NUM_CORNERS = 4;
	localparam int NUM_EDGES   = 4;
	localparam int CFG_IDX_W   = 4;
	localparam int MASK_W      = 8;

	localparam int PIX_W    = PIXEL_COORD_BITS;
	localparam int IN_W     = ((2 * PIX_W + 7) / 8) * 8;
	localparam int CMP_W    = (PIX_W > CORNER_W) ? PIX_W : CORNER_W;
	localparam int A_W      = CORNER_W + 1;
	localparam int XS_W     = PIX_W + 1;
	localparam int PROD_W   = A_W + XS_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int P_W      = 2 * CORNER_W;
	localparam int C_W      = P_W + 1;
	localparam int SH_W     = SUM_W + CORNER_FRAC_BITS;
	localparam int V_W      = ((SH_W > C_W) ? SH_W : C_W) + 1;

	localparam logic [MASK_W-1:0] MASK_IN  = {MASK_W{1'b1}};
	localparam logic [MASK_W-1:0] MASK_OUT = '0;

	// edge order: left, right, top, bottom; edge runs from corner P to corner Q
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_TOP    = 2;
	localparam int EDGE_BOTTOM = 3;
	localparam int EDGE_P [NUM_EDGES] = '{0, 1, 0, 3};
	localparam int EDGE_Q [NUM_EDGES] = '{3, 2, 1, 2};

	typedef logic signed [CORNER_W-1:0] corner_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER0_X = 4'd0,
		REG_CORNER0_Y = 4'd1,
		REG_CORNER1_X = 4'd2,
		REG_CORNER1_Y = 4'd3,
		REG_CORNER2_X = 4'd4,
		REG_CORNER2_Y = 4'd5,
		REG_CORNER3_X = 4'd6,
		REG_CORNER3_Y = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [A_W-1:0] b;
		logic signed [P_W-1:0] p1;
		logic signed [P_W-1:0] p2;
	} edge_coef_t;

	typedef struct packed {
		logic [CMP_W-1:0] lo_x;
		logic [CMP_W-1:0] hi_x;
		logic [CMP_W-1:0] lo_y;
		logic [CMP_W-1:0] hi_y;
	} box_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} edge_sign_t;

	// floor(raw / 2^F), clamped below at zero
	function automatic logic [CMP_W-1:0] box_limit(input corner_t raw);
		corner_t sh;
		sh = raw >>> CORNER_FRAC_BITS;
		if (raw <= 0)
			return '0;
		return CMP_W'(unsigned'(sh));
	endfunction

endpackage

FILE: rtl/core/qrm_coef.sv
module qrm_coef (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_we,
	input  logic [qrm_pkg::CFG_IDX_W-1:0]                     cfg_index,
	input  logic [qrm_pkg::CORNER_W-1:0]                      cfg_data,
	output qrm_pkg::edge_coef_t [qrm_pkg::NUM_EDGES-1:0]      coef,
	output qrm_pkg::box_t                                     box
);

	qrm_pkg::corner_t corner_x_q [qrm_pkg::NUM_CORNERS];
	qrm_pkg::corner_t corner_y_q [qrm_pkg::NUM_CORNERS];
	qrm_pkg::edge_coef_t [qrm_pkg::NUM_EDGES-1:0] coef_q;
	qrm_pkg::box_t box_q;
	qrm_pkg::box_t box_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qrm_pkg::NUM_CORNERS; i++) begin
				corner_x_q[i] <= '0;
				corner_y_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (qrm_pkg::cfg_reg_t'(cfg_index))
				qrm_pkg::REG_CORNER0_X: corner_x_q[0] <= cfg_data;
				qrm_pkg::REG_CORNER0_Y: corner_y_q[0] <= cfg_data;
				qrm_pkg::REG_CORNER1_X: corner_x_q[1] <= cfg_data;
				qrm_pkg::REG_CORNER1_Y: corner_y_q[1] <= cfg_data;
				qrm_pkg::REG_CORNER2_X: corner_x_q[2] <= cfg_data;
				qrm_pkg::REG_CORNER2_Y: corner_y_q[2] <= cfg_data;
				qrm_pkg::REG_CORNER3_X: corner_x_q[3] <= cfg_data;
				qrm_pkg::REG_CORNER3_Y: corner_y_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		qrm_pkg::corner_t min_x, max_x, min_y, max_y;
		min_x = corner_x_q[0];
		max_x = corner_x_q[0];
		min_y = corner_y_q[0];
		max_y = corner_y_q[0];
		for (int i = 1; i < qrm_pkg::NUM_CORNERS; i++) begin
			if (corner_x_q[i] < min_x) min_x = corner_x_q[i];
			if (corner_x_q[i] > max_x) max_x = corner_x_q[i];
			if (corner_y_q[i] < min_y) min_y = corner_y_q[i];
			if (corner_y_q[i] > max_y) max_y = corner_y_q[i];
		end
		box_d.lo_x = qrm_pkg::box_limit(min_x);
		box_d.hi_x = qrm_pkg::box_limit(max_x);
		box_d.lo_y = qrm_pkg::box_limit(min_y);
		box_d.hi_y = qrm_pkg::box_limit(max_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			box_q <= '0;
		else
			box_q <= box_d;
	end

	// A = Qy - Py, B = Px - Qx, C = p1 - p2 with p1 = Py*Qx, p2 = Qy*Px
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else begin
			for (int e = 0; e < qrm_pkg::NUM_EDGES; e++) begin
				coef_q[e].a  <= qrm_pkg::A_W'(corner_y_q[qrm_pkg::EDGE_Q[e]])
					- qrm_pkg::A_W'(corner_y_q[qrm_pkg::EDGE_P[e]]);
				coef_q[e].b  <= qrm_pkg::A_W'(corner_x_q[qrm_pkg::EDGE_P[e]])
					- qrm_pkg::A_W'(corner_x_q[qrm_pkg::EDGE_Q[e]]);
				coef_q[e].p1 <= qrm_pkg::P_W'(corner_y_q[qrm_pkg::EDGE_P[e]])
					* qrm_pkg::P_W'(corner_x_q[qrm_pkg::EDGE_Q[e]]);
				coef_q[e].p2 <= qrm_pkg::P_W'(corner_y_q[qrm_pkg::EDGE_Q[e]])
					* qrm_pkg::P_W'(corner_x_q[qrm_pkg::EDGE_P[e]]);
			end
		end
	end

	assign coef = coef_q;
	assign box  = box_q;

endmodule

FILE: rtl/core/qrm_edge.sv
module qrm_edge (
	input  logic                              clk,
	input  qrm_pkg::stage_en_t                en,
	input  logic [qrm_pkg::PIX_W-1:0]         x_s1,
	input  logic [qrm_pkg::PIX_W-1:0]         y_s1,
	input  qrm_pkg::edge_coef_t               coef,
	output qrm_pkg::edge_sign_t               sign_s4
);

	logic signed [qrm_pkg::XS_W-1:0]   xs;
	logic signed [qrm_pkg::XS_W-1:0]   ys;
	logic signed [qrm_pkg::PROD_W-1:0] ax_d;
	logic signed [qrm_pkg::PROD_W-1:0] by_d;
	logic signed [qrm_pkg::PROD_W-1:0] ax_s2;
	logic signed [qrm_pkg::PROD_W-1:0] by_s2;
	logic signed [qrm_pkg::SUM_W-1:0]  sum_d;
	logic signed [qrm_pkg::C_W-1:0]    c_d;
	logic signed [qrm_pkg::SUM_W-1:0]  sum_s3;
	logic signed [qrm_pkg::C_W-1:0]    c_s3;
	logic signed [qrm_pkg::V_W-1:0]    v_d;
	qrm_pkg::edge_sign_t               sign_d;
	qrm_pkg::edge_sign_t               sign_q;

	assign xs = signed'({1'b0, x_s1});
	assign ys = signed'({1'b0, y_s1});

	assign ax_d = qrm_pkg::PROD_W'(coef.a) * qrm_pkg::PROD_W'(xs);
	assign by_d = qrm_pkg::PROD_W'(coef.b) * qrm_pkg::PROD_W'(ys);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ax_s2 <= ax_d;
			by_s2 <= by_d;
		end
	end

	assign sum_d = qrm_pkg::SUM_W'(ax_s2) + qrm_pkg::SUM_W'(by_s2);
	assign c_d   = qrm_pkg::C_W'(coef.p1) - qrm_pkg::C_W'(coef.p2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= sum_d;
			c_s3   <= c_d;
		end
	end

	// edge value scaled by 2^(2F): (A*x + B*y) * 2^F + C
	assign v_d = (qrm_pkg::V_W'(sum_s3) <<< qrm_pkg::CORNER_FRAC_BITS)
		+ qrm_pkg::V_W'(c_s3);
	assign sign_d.neg = v_d[qrm_pkg::V_W-1];
	assign sign_d.pos = !v_d[qrm_pkg::V_W-1] && (v_d != '0);

	always_ff @(posedge clk) begin
		if (en.s4)
			sign_q <= sign_d;
	end

	assign sign_s4 = sign_q;

endmodule

FILE: rtl/core/quad_region_mask_unit.sv
// Pixel-in-quadrilateral mask.
// Slave stream s_axis carries one pixel coordinate per transaction; master
// stream m_axis returns one mask byte per transaction: 255 when the pixel lies
// inside the quadrilateral spanned by the four corner registers, else 0.
// Corners (signed, 4 fraction bits) are written through cfg_we/cfg_index/
// cfg_data; indexes above 7 are ignored. A corner write feeds a registered
// coefficient stage (edge terms and bounding box), so it applies to every
// pixel accepted from the next cycle on.
// An accepted pixel passes through the input, multiply, sum, sign and decision
// registers in turn before its mask transaction is offered on m_axis.
// Throughput: one pixel per cycle while m_axis_tready is high; the five-stage
// pipeline (input register, edge multiplies, edge sums, edge signs, inside
// decision) takes a new item each cycle unless a stall has filled every stage.
// Reset clears all corners to zero and empties the pipeline.
// When m_axis_tready is low the result holds in the output stage, empty stages
// behind it keep filling, and s_axis_tready drops only once every stage holds
// a valid item.
module quad_region_mask_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [qrm_pkg::IN_W-1:0]              s_axis_tdata,  // pixel_x, pixel_y
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [qrm_pkg::MASK_W-1:0]            m_axis_tdata,  // mask_value
	input  logic                                  cfg_we,
	input  logic [qrm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [qrm_pkg::CORNER_W-1:0]          cfg_data
);

	qrm_pkg::edge_coef_t [qrm_pkg::NUM_EDGES-1:0] coef;
	qrm_pkg::box_t                                box;
	qrm_pkg::edge_sign_t                          sign_s4 [qrm_pkg::NUM_EDGES];
	qrm_pkg::stage_en_t                           en;

	logic en_s1;
	logic en_s5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [qrm_pkg::PIX_W-1:0] x_s1;
	logic [qrm_pkg::PIX_W-1:0] y_s1;
	logic box_ok_d;
	logic box_ok_s2, box_ok_s3, box_ok_s4;
	logic lr_ok, tb_ok;
	logic [qrm_pkg::MASK_W-1:0] mask_d;
	logic [qrm_pkg::MASK_W-1:0] mask_s5;

	qrm_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.box       (box)
	);

	// a stage loads when it is empty or the stage after it moves on
	assign en_s5  = !valid_s5 || m_axis_tready;
	assign en.s4  = !valid_s4 || en_s5;
	assign en.s3  = !valid_s3 || en.s4;
	assign en.s2  = !valid_s2 || en.s3;
	assign en_s1  = !valid_s1 || en.s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			x_s1 <= s_axis_tdata[qrm_pkg::PIX_W-1:0];
			y_s1 <= s_axis_tdata[2*qrm_pkg::PIX_W-1:qrm_pkg::PIX_W];
		end
	end

	assign box_ok_d = (qrm_pkg::CMP_W'(x_s1) >= box.lo_x) && (qrm_pkg::CMP_W'(x_s1) <= box.hi_x)
		&& (qrm_pkg::CMP_W'(y_s1) >= box.lo_y) && (qrm_pkg::CMP_W'(y_s1) <= box.hi_y);

	always_ff @(posedge clk) begin
		if (en.s2) box_ok_s2 <= box_ok_d;
		if (en.s3) box_ok_s3 <= box_ok_s2;
		if (en.s4) box_ok_s4 <= box_ok_s3;
	end

	for (genvar e = 0; e < qrm_pkg::NUM_EDGES; e++) begin : g_edge
		qrm_edge u_edge (
			.clk     (clk),
			.en      (en),
			.x_s1    (x_s1),
			.y_s1    (y_s1),
			.coef    (coef[e]),
			.sign_s4 (sign_s4[e])
		);
	end

	// a pair passes unless both edge values share a strict sign
	assign lr_ok = !((sign_s4[qrm_pkg::EDGE_LEFT].pos && sign_s4[qrm_pkg::EDGE_RIGHT].pos)
		|| (sign_s4[qrm_pkg::EDGE_LEFT].neg && sign_s4[qrm_pkg::EDGE_RIGHT].neg));
	assign tb_ok = !((sign_s4[qrm_pkg::EDGE_TOP].pos && sign_s4[qrm_pkg::EDGE_BOTTOM].pos)
		|| (sign_s4[qrm_pkg::EDGE_TOP].neg && sign_s4[qrm_pkg::EDGE_BOTTOM].neg));

	assign mask_d = (box_ok_s4 && lr_ok && tb_ok) ? qrm_pkg::MASK_IN : qrm_pkg::MASK_OUT;

	always_ff @(posedge clk) begin
		if (en_s5)
			mask_s5 <= mask_d;
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = mask_s5;

	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == qrm_pkg::MASK_IN || m_axis_tdata == qrm_pkg::MASK_OUT))
		else $error("mask byte is neither inside nor outside code");

	a_box_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && en_s5 && !box_ok_s4) |=> (mask_s5 == qrm_pkg::MASK_OUT))
		else $error("pixel outside bounding box was marked inside");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en.s2) |=> (valid_s1 && $stable(x_s1) && $stable(y_s1)))
		else $error("stalled first stage lost its coordinate");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tready == 1'b0) |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled while a pipeline stage was empty");

endmodule
